[hw/rtl/b64enc_pkg.sv]
// Shared types, constants and the Base64 alphabet for the stream encoder.
package b64enc_pkg;

    localparam int QueueDepth = 2;

    localparam logic [6:0] PadChar   = 7'h3D;
    localparam logic [6:0] PlusChar  = 7'h2B;
    localparam logic [6:0] SlashChar = 7'h2F;
    localparam logic [5:0] SextetMask = 6'h3F;

    localparam logic KindData = 1'b0;
    localparam logic KindEnd  = 1'b1;

    // One group of up to three bytes, left aligned, with the number of '=' to emit.
    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  pad_cnt;
    } group_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    function automatic logic [6:0] b64_char(input logic [5:0] sextet);
        logic [6:0] s;
        logic [6:0] ch;
        s = {1'b0, sextet & SextetMask};
        case (s) inside
            [7'd0:7'd25]:  ch = 7'(7'd65 + s);
            [7'd26:7'd51]: ch = 7'(7'd97 + s - 7'd26);
            [7'd52:7'd61]: ch = 7'(7'd48 + s - 7'd52);
            7'd62:         ch = PlusChar;
            default:       ch = SlashChar;
        endcase
        return ch;
    endfunction

endpackage

[hw/rtl/b64enc_if.sv]
// Valid/ready channels for input words and output characters.
interface b64enc_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface b64enc_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       run_last;

    modport source (output valid, output out_char, output run_last, input ready);
    modport sink   (input valid, input out_char, input run_last, output ready);
endinterface

[hw/rtl/b64enc_front.sv]
// Front end: collects bytes into groups and queues complete or flushed groups.
module b64enc_front
    import b64enc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  data_byte,
    input  queue_stat_t q_stat,
    output logic        push,
    output group_t      push_group
);

    logic [15:0] pend_reg, pend_next;
    logic [1:0]  count_reg, count_next;
    logic        accept;
    logic        two_pending;

    assign in_ready    = !q_stat.full;
    assign accept      = in_valid && in_ready;
    // an out-of-range count acts as two pending bytes
    assign two_pending = (count_reg >= 2'd2);

    always_comb
    begin
        pend_next  = pend_reg;
        count_next = count_reg;
        push       = 1'b0;
        push_group = '{bits: {pend_reg, data_byte}, pad_cnt: 2'd0};
        if (accept)
        begin
            if (kind == KindData)
            begin
                if (!two_pending)
                begin
                    pend_next  = {pend_reg[7:0], data_byte};
                    count_next = 2'(count_reg + 2'd1);
                end
                else
                begin
                    push       = 1'b1;
                    pend_next  = '0;
                    count_next = '0;
                end
            end
            else
            begin
                if (two_pending)
                begin
                    push       = 1'b1;
                    push_group = '{bits: {pend_reg, 8'h00}, pad_cnt: 2'd1};
                end
                else if (count_reg == 2'd1)
                begin
                    push       = 1'b1;
                    push_group = '{bits: {pend_reg[7:0], 16'h0000}, pad_cnt: 2'd2};
                end
                pend_next  = '0;
                count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            pend_reg  <= pend_next;
            count_reg <= count_next;
        end
    end

endmodule

[hw/rtl/b64enc_queue.sv]
// Short group queue between front and back ends.
module b64enc_queue
    import b64enc_pkg::*;
#(
    parameter int Depth = QueueDepth
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  group_t      push_group,
    input  logic        pop,
    output group_t      head,
    output queue_stat_t stat
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    group_t            store_reg [Depth];
    logic [PtrW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0]   cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign stat.full  = (cnt_reg == CntW'(Depth));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = store_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = CntW'(cnt_reg + 1'b1);
        else if (do_pop && !do_push)
            cnt_next = CntW'(cnt_reg - 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= push_group;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(Depth - 1)) ? '0
                                                               : PtrW'(wr_ptr_reg + 1'b1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(Depth - 1)) ? '0
                                                               : PtrW'(rd_ptr_reg + 1'b1);
        end
    end

endmodule

[hw/rtl/b64enc_back.sv]
// Back end: turns each queued group into four characters, one per cycle while the output is ready.
module b64enc_back
    import b64enc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  group_t      head,
    input  queue_stat_t q_stat,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [6:0]  out_char,
    output logic        run_last
);

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [6:0] char_reg, char_next;
    logic       last_reg;
    logic       load;
    logic [5:0] sextet;
    logic       is_pad;

    assign load = !q_stat.empty && (!valid_reg || out_ready);
    // release the group as its fourth character is loaded into the output register
    assign pop  = load && (idx_reg == 2'd3);

    always_comb
    begin
        case (idx_reg)
            2'd0:    sextet = head.bits[23:18];
            2'd1:    sextet = head.bits[17:12];
            2'd2:    sextet = head.bits[11:6];
            default: sextet = head.bits[5:0];
        endcase
        is_pad    = ({1'b0, idx_reg} >= 3'(3'd4 - {1'b0, head.pad_cnt}));
        char_next = is_pad ? PadChar : b64_char(sextet);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= 2'(idx_reg + 2'd1);
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= char_next;
            last_reg <= (idx_reg == 2'd3);
        end
    end

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign run_last  = last_reg;

endmodule

[hw/rtl/base64_stream_encoder.sv]
// Base64 stream encoder: byte words in, one character word out per cycle while ready.
// Path: the word that completes or flushes a group writes it into the group queue, and
// the back end then loads its four characters into the output register in order.
// Throughput: one input word per cycle while the group queue has room; the output
// runs at one character per cycle while result is ready, so 3 bytes give 4 characters.
// Reset (async, active low) clears the pending bytes, the queue and the output.
module base64_stream_encoder
    import b64enc_pkg::*;
#(
    parameter int QDepth = QueueDepth
)
(
    input  logic          clk,
    input  logic          rst_n,
    b64enc_in_if.sink     item,
    b64enc_out_if.source  result
);

    queue_stat_t q_stat;
    group_t      push_group;
    group_t      head;
    logic        push;
    logic        pop;

    b64enc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (item.valid),
        .in_ready   (item.ready),
        .kind       (item.kind),
        .data_byte  (item.data_byte),
        .q_stat     (q_stat),
        .push       (push),
        .push_group (push_group)
    );

    b64enc_queue #(.Depth(QDepth)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .pop        (pop),
        .head       (head),
        .stat       (q_stat)
    );

    b64enc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_char  (result.out_char),
        .run_last  (result.run_last)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("group pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("group popped from an empty queue");

    a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (result.valid && result.run_last))
        else $error("group retired without a last character");

endmodule
